FILE: hdl/lcgrm_pkg.sv
// Shared types and constants for the LCG random-modulo block.
// No dependencies; imported by lcgrm_dp, lcgrm_ctrl and lcg_random_modulo.
package lcgrm_pkg;

    localparam logic [31:0] C_LCG_MUL   = 32'd1103515245;
    localparam logic [31:0] C_LCG_ADD   = 32'd12345;
    localparam logic [31:0] C_SEED_RST  = 32'd1;

    localparam int C_GEN_STEPS  = 3;
    localparam int C_NUM_BITS   = 31;
    localparam int C_FIRST_BITS = 11;
    localparam int C_LATER_BITS = 10;
    localparam int C_CNT_W      = $clog2(C_NUM_BITS);

    localparam logic [C_CNT_W-1:0] C_GEN_LAST = C_CNT_W'(C_GEN_STEPS - 1);
    localparam logic [C_CNT_W-1:0] C_DIV_LAST = C_CNT_W'(C_NUM_BITS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_GEN,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic gen_step;
        logic gen_first;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

endpackage

FILE: hdl/lcgrm_dp.sv
// Datapath: seed register, generator state, slice accumulator and
// restoring divider for the remainder. Depends on lcgrm_pkg.
module lcgrm_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [31:0]      i_cfg_data,
    input  logic [31:0]      i_modulus,
    input  lcgrm_pkg::t_dp_cmd i_cmd,
    output logic [31:0]      o_random_value,
    output logic             o_zero_modulus
);
    import lcgrm_pkg::*;

    logic [31:0]           r_seed;
    logic                  r_seeded;
    logic [31:0]           r_state;
    logic [31:0]           n_state;
    logic [C_NUM_BITS-1:0] r_acc;
    logic [C_NUM_BITS-1:0] n_acc_gen;
    logic [31:0]           r_mod;
    logic [31:0]           r_rem;
    logic [32:0]           rem_sh;
    logic [32:0]           rem_sub;
    logic [31:0]           n_rem;
    logic [C_FIRST_BITS-1:0] slice;

    assign n_state = 32'(r_state * C_LCG_MUL) + C_LCG_ADD;

    always_comb begin
        slice = n_state[16 +: C_FIRST_BITS];
        if (i_cmd.gen_first) begin
            n_acc_gen = C_NUM_BITS'(slice);
        end else begin
            n_acc_gen = {r_acc[C_NUM_BITS-1-C_LATER_BITS:0],
                         slice[C_LATER_BITS-1:0]};
        end
    end

    // one quotient bit per cycle: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_sh  = {r_rem, r_acc[C_NUM_BITS-1]};
        rem_sub = rem_sh - {1'b0, r_mod};
        if (rem_sh >= {1'b0, r_mod}) begin
            n_rem = rem_sub[31:0];
        end else begin
            n_rem = rem_sh[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= C_SEED_RST;
            r_seeded <= 1'b0;
            r_state  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_data;
            end
            if (i_cmd.load && !r_seeded) begin
                r_state  <= r_seed;
                r_seeded <= 1'b1;
            end else if (i_cmd.gen_step) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mod <= i_modulus;
            r_rem <= '0;
            r_acc <= '0;
        end else if (i_cmd.gen_step) begin
            r_acc <= n_acc_gen;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_acc <= {r_acc[C_NUM_BITS-2:0], 1'b0};
        end
        if (i_cmd.out_load) begin
            o_zero_modulus <= (r_mod == '0);
            o_random_value <= (r_mod == '0) ? '0 : r_rem;
        end
    end

endmodule

FILE: hdl/lcgrm_ctrl.sv
// Controller: sequences load, generator steps, divide steps and the output word.
// Holds the step counter and output valid. Depends on lcgrm_pkg.
module lcgrm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output lcgrm_pkg::t_dp_cmd o_cmd
);
    import lcgrm_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [C_CNT_W-1:0] r_cnt;
    logic [C_CNT_W-1:0] n_cnt;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_GEN;
            S_GEN:  if (r_cnt == C_GEN_LAST) n_state = S_DIV;
            S_DIV:  if (r_cnt == C_DIV_LAST) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_stall     = 1'b1;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        case (r_state)
            S_IDLE: begin
                o_stall  = 1'b0;
                o_cmd.load = i_valid;
                n_cnt    = '0;
            end
            S_GEN: begin
                o_cmd.gen_step  = 1'b1;
                o_cmd.gen_first = (r_cnt == '0);
                n_cnt = (r_cnt == C_GEN_LAST) ? '0 : r_cnt + 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

FILE: hdl/lcg_random_modulo.sv
// Each word runs 3 generator steps, 31 divide steps and 1 output load, the
// divider taking one remainder bit per cycle. No new word is accepted until
// the last one has been loaded into the output register.
// A finished word waits in the output register while the next word is taken.
// Reset (i_rst_n low, synchronous): idle, no output, seed 1, generator unseeded.
// Depends on lcgrm_pkg, lcgrm_ctrl and lcgrm_dp.
module lcg_random_modulo (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_modulus,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_random_value,
    output logic        o_zero_modulus
);
    import lcgrm_pkg::*;

    t_dp_cmd cmd;

    lcgrm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    lcgrm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_modulus      (i_modulus),
        .i_cmd          (cmd),
        .o_random_value (o_random_value),
        .o_zero_modulus (o_zero_modulus)
    );

endmodule

FILE: hdl/lcgrm_chk.sv
// Port-level checker for lcg_random_modulo, attached by bind.
// Depends only on the top-level ports.
module lcgrm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_random_value,
    input logic        o_zero_modulus
);

    // a zero modulus always yields a zero value
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_modulus |-> o_random_value == 32'd0)
        else $error("zero modulus with nonzero value");

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_random_value)
                               && $stable(o_zero_modulus))
        else $error("output word changed while stalled");

    // an accepted word makes the input busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accept");

    // the input only goes busy because a word was taken
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(i_valid))
        else $error("stall rose without an accepted word");

endmodule

bind lcg_random_modulo lcgrm_chk u_lcgrm_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_random_value (o_random_value),
    .o_zero_modulus (o_zero_modulus)
);

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench for lcg_random_modulo: a directed table, then random moduli checked
// against a local model of the generator and the modulo. Needs only the block's RTL.
module tb;

    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;
    localparam int DIR_ROWS    = 22;
    localparam int CHUNK_WORDS = 550;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] value;
        logic        zero;
    } t_draw;

    typedef struct packed {
        logic [31:0] modulus;
        logic        fixed;
        logic [31:0] value;
        logic        zero;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_modulus;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_random_value;
    logic        o_zero_modulus;

    // Generator copy: seed register, state, seeded flag.
    logic [31:0] seed_reg;
    logic [31:0] rng_state;
    logic        rng_seeded;

    t_draw pending_draws[$];
    t_draw rx_draw;
    int    n_errors;
    int    n_words_out;
    int    cycles;
    int    tx_quiet;
    int    rx_quiet;
    int    rx_wait;
    int    rx_hold;

    // Fixed values only where obvious: zero modulus and modulus one.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{32'd0,          1'b1, 32'd0, 1'b1},
        '{32'd1,          1'b1, 32'd0, 1'b0},
        '{32'd2,          1'b0, 32'd0, 1'b0},
        '{32'd3,          1'b0, 32'd0, 1'b0},
        '{32'hFFFF_FFFF,  1'b0, 32'd0, 1'b0},
        '{32'hFFFF_FFFE,  1'b0, 32'd0, 1'b0},
        '{32'h8000_0000,  1'b0, 32'd0, 1'b0},
        '{32'h8000_0001,  1'b0, 32'd0, 1'b0},
        '{32'h7FFF_FFFF,  1'b0, 32'd0, 1'b0},
        '{32'h7FFF_FFFE,  1'b0, 32'd0, 1'b0},
        '{32'h4000_0000,  1'b0, 32'd0, 1'b0},
        '{32'h0000_FFFF,  1'b0, 32'd0, 1'b0},
        '{32'h0001_0000,  1'b0, 32'd0, 1'b0},
        '{32'd10,         1'b0, 32'd0, 1'b0},
        '{32'd1000,       1'b0, 32'd0, 1'b0},
        '{32'h5555_5555,  1'b0, 32'd0, 1'b0},
        '{32'hAAAA_AAAA,  1'b0, 32'd0, 1'b0},
        '{32'd0,          1'b1, 32'd0, 1'b1},
        '{32'd1,          1'b1, 32'd0, 1'b0},
        '{32'd7,          1'b0, 32'd0, 1'b0},
        '{32'd2047,       1'b0, 32'd0, 1'b0},
        '{32'd1024,       1'b0, 32'd0, 1'b0}
    };

    lcg_random_modulo u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_modulus      (i_modulus),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_random_value (o_random_value),
        .o_zero_modulus (o_zero_modulus)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("tb: word %0d: %s", n_words_out, msg);
        n_errors++;
    endtask

    // Random idle gap, with the odd run of back-to-back words.
    function automatic int pick_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 31) == 0) begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    // Three generator steps give 11 + 10 + 10 bits, then reduce by the modulus.
    function automatic void predict_draw(input logic [31:0] m, output t_draw d);
        logic [31:0] s;
        logic [30:0] num;
        if (!rng_seeded) begin
            rng_state  = seed_reg;
            rng_seeded = 1'b1;
        end
        s = rng_state * LCG_MUL + LCG_ADD;
        num[30:20] = s[26:16];
        s = s * LCG_MUL + LCG_ADD;
        num[19:10] = s[25:16];
        s = s * LCG_MUL + LCG_ADD;
        num[9:0] = s[25:16];
        rng_state = s;
        d.zero  = (m == 32'd0);
        d.value = d.zero ? 32'd0 : {1'b0, num} % m;
    endfunction

    function automatic logic [31:0] random_modulus();
        int k;
        k = $urandom_range(0, 19);
        case (k)
            0:               return 32'd0;
            1, 2, 3, 4:      return $urandom_range(1, 16);
            5, 6, 7:         return 32'd1 << $urandom_range(0, 31);
            8, 9:            return 32'h8000_0000 + $urandom_range(0, 3) - 32'd2;
            10, 11, 12:      return $urandom_range(1, 65535);
            default:         return $urandom;
        endcase
    endfunction

    task automatic offer_word(input logic [31:0] m, input logic fixed,
                              input logic [31:0] fval, input logic fzero);
        int    gap;
        t_draw d;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_modulus <= m;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predict_draw(m, d);
        if (fixed) begin
            d.value = fval;
            d.zero  = fzero;
        end
        pending_draws.push_back(d);
    endtask

    task automatic drain_words();
        i_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
    endtask

    task automatic seed_write(input logic [31:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        seed_reg    = v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Receiver: check each word, then stall a drawn number of cycles.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_draws.size() == 0) begin
                report_mismatch($sformatf("unexpected word value %0d zero %0b",
                                          o_random_value, o_zero_modulus));
            end else begin
                rx_draw = pending_draws.pop_front();
                if (o_random_value !== rx_draw.value)
                    report_mismatch($sformatf("random_value %0d, want %0d",
                                              o_random_value, rx_draw.value));
                if (o_zero_modulus !== rx_draw.zero)
                    report_mismatch($sformatf("zero_modulus %0b, want %0b",
                                              o_zero_modulus, rx_draw.zero));
            end
            n_words_out++;
            rx_wait = pick_gap(rx_quiet);
            // Hold off long enough for the block to back up into its input.
            if (n_words_out == HOLD_AT)
                rx_hold = HOLD_CYCLES;
        end
        if (rx_hold > 0) begin
            i_stall <= 1'b1;
            rx_hold--;
        end else if (rx_wait > 0) begin
            i_stall <= 1'b1;
            rx_wait--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    initial begin
        int i;
        int chunk;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = 32'd0;
        i_valid    = 1'b0;
        i_modulus  = 32'd0;
        i_stall    = 1'b0;
        seed_reg   = 32'd1;
        rng_state  = 32'd0;
        rng_seeded = 1'b0;
        n_errors   = 0;
        n_words_out = 0;
        cycles     = 0;
        tx_quiet   = 0;
        rx_quiet   = 0;
        rx_wait    = 0;
        rx_hold    = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Seed before the first word: zero, all ones, random, or leave the reset value.
        case ($urandom_range(0, 3))
            0: seed_write(32'd0);
            1: seed_write(32'hFFFF_FFFF);
            2: seed_write($urandom);
            default: @(posedge i_clk);
        endcase

        for (i = 0; i < DIR_ROWS; i++)
            offer_word(dir_rows[i].modulus, dir_rows[i].fixed,
                       dir_rows[i].value, dir_rows[i].zero);
        drain_words();

        // Later seed writes must leave the running sequence alone.
        seed_write(32'd0);
        for (chunk = 0; chunk < 3; chunk++) begin
            for (i = 0; i < CHUNK_WORDS; i++)
                offer_word(random_modulus(), 1'b0, 32'd0, 1'b0);
            drain_words();
            if (chunk == 0)
                seed_write(32'hFFFF_FFFF);
            else if (chunk == 1)
                seed_write($urandom);
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && pending_draws.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
